FILE: rtl/core/matrix_multiply_accumulate_defines.svh
// ---------------------------------------------------------------------------
// Matrix multiply-accumulate assertion macros
// Shorthand for clocked assertions used by the port checker.
// ---------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ACCUMULATE_DEFINES_SVH
`define MATRIX_MULTIPLY_ACCUMULATE_DEFINES_SVH

// checked only while out of reset
`define MMA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked through reset as well
`define MMA_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: rtl/core/mma_pkg.sv
// ---------------------------------------------------------------------------
// Matrix multiply-accumulate package
// Widths, codes, microcode ROM and arithmetic helpers.
// ---------------------------------------------------------------------------
package mma_pkg;

  localparam int MAX_DIM = 8;
  localparam int DIM_W   = 4;                          // config register width
  localparam int POS_W   = $clog2(MAX_DIM);            // row / col / term position
  localparam int IDX_W   = $clog2(MAX_DIM * MAX_DIM);  // store address
  localparam int CNT_W   = IDX_W + 1;                  // element count
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int VAL_W   = 48;
  localparam int AB_W    = 16;
  localparam int PROD_W  = 2 * AB_W;
  localparam int STEP_W  = 3;

  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_LOAD_C  = 2'd2,
    OP_COMPUTE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_ROWS  = 2'd0,
    REG_COLS  = 2'd1,
    REG_INNER = 2'd2
  } reg_idx_t;

  // microprogram steps
  localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_RDC   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_LDACC = 3'd2;
  localparam logic [STEP_W-1:0] STEP_RDAB  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_MUL   = 3'd4;
  localparam logic [STEP_W-1:0] STEP_ACC   = 3'd5;
  localparam logic [STEP_W-1:0] STEP_WB    = 3'd6;

  typedef enum logic [1:0] {
    COND_NEXT  = 2'd0,  // fall through
    COND_START = 2'd1,  // jump on compute transaction, else hold
    COND_LOOP  = 2'd2,  // jump while terms remain
    COND_EMIT  = 2'd3   // hold until output slot free; idle after last element
  } cond_t;

  typedef struct packed {
    cond_t              cond;
    logic [STEP_W-1:0]  target;
    logic               elem_init;
    logic               ld_acc;
    logic               mul_en;
    logic               acc_en;
    logic               wb_en;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t uw;
    uw = '{cond: COND_NEXT, target: STEP_IDLE, elem_init: 1'b0, ld_acc: 1'b0,
           mul_en: 1'b0, acc_en: 1'b0, wb_en: 1'b0};
    case (step)
      STEP_IDLE: begin
        uw.cond   = COND_START;
        uw.target = STEP_RDC;
      end
      STEP_RDC:   uw.elem_init = 1'b1;
      STEP_LDACC: uw.ld_acc    = 1'b1;
      STEP_RDAB:  uw.cond      = COND_NEXT;
      STEP_MUL:   uw.mul_en    = 1'b1;
      STEP_ACC: begin
        uw.acc_en = 1'b1;
        uw.cond   = COND_LOOP;
        uw.target = STEP_RDAB;
      end
      STEP_WB: begin
        uw.wb_en  = 1'b1;
        uw.cond   = COND_EMIT;
        uw.target = STEP_RDC;
      end
      default: begin
        uw.cond   = COND_START;
        uw.target = STEP_IDLE;
      end
    endcase
    return uw;
  endfunction

  // 0 acts as 1, anything above MAX_DIM acts as MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    if (d == '0) return DIM_W'(1);
    if (d > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return d;
  endfunction

  function automatic logic signed [AB_W-1:0] sat16(input logic signed [VAL_W-1:0] v);
    if (v > 48'sd32767) return 16'sh7fff;
    if (v < -48'sd32768) return 16'sh8000;
    return v[AB_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_add48(
    input logic signed [VAL_W-1:0]  acc,
    input logic signed [PROD_W-1:0] p
  );
    logic signed [VAL_W:0] s;
    s = {acc[VAL_W-1], acc} + {{(VAL_W + 1 - PROD_W){p[PROD_W-1]}}, p};
    if (s[VAL_W] != s[VAL_W-1]) begin
      return s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end
    return s[VAL_W-1:0];
  endfunction

endpackage

FILE: rtl/core/matrix_multiply_accumulate.sv
// ---------------------------------------------------------------------------
// Matrix multiply-accumulate (C = C + A*B), microcoded sequencer
// Loads: one transaction per cycle while idle, written to the stores in the
// accepting cycle. Compute: input stalled; each term takes a store read, a
// registered multiply and a saturating add. Results leave one per element.
// Reset (synchronous, rst_n low): dims to 8, load indices to 0, C reads as zero.
// ---------------------------------------------------------------------------
module matrix_multiply_accumulate
  import mma_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,

  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_opcode,
  input  logic signed [VAL_W-1:0] in_value,

  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] out_c_value,
  output logic                    out_last_element,

  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [DIM_W-1:0]        cfg_data
);

  // configuration
  logic [DIM_W-1:0] rows_r, cols_r, inner_r;
  logic [DIM_W-1:0] dim_m, dim_n, dim_k;
  logic [POS_W-1:0] m_last, n_last, k_last;
  logic [CNT_W-1:0] cnt_a, cnt_b, cnt_c;

  // load indices
  logic [IDX_W-1:0] a_idx_r, b_idx_r, c_idx_r;
  logic [IDX_W-1:0] a_slot, b_slot, c_slot;
  logic [IDX_W-1:0] a_idx_nxt, b_idx_nxt, c_idx_nxt;

  // sequencer
  logic [STEP_W-1:0] upc_r, upc_nxt;
  ucode_t            uw;
  logic              in_acc, start, out_free, wb_fire, last_elem, t_more;

  // walk counters and addresses
  logic [POS_W-1:0] i_r, j_r, t_r;
  logic [IDX_W-1:0] c_addr_r, a_addr_r, b_addr_r, a_base_r;

  // datapath
  logic signed [VAL_W-1:0]  acc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [AB_W-1:0]   a_rd_r, b_rd_r;
  logic signed [VAL_W-1:0]  c_rd_r;
  logic                     c_vld_rd_r;

  // stores
  logic signed [AB_W-1:0]  a_mem [DEPTH];
  logic signed [AB_W-1:0]  b_mem [DEPTH];
  logic signed [VAL_W-1:0] c_mem [DEPTH];
  logic [DEPTH-1:0]        c_vld_r;
  logic                    a_we, b_we, c_we;
  logic [IDX_W-1:0]        c_waddr;
  logic signed [VAL_W-1:0] c_wdata;
  logic signed [AB_W-1:0]  ab_load;

  // output register
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_c_value_r;
  logic                    out_last_r;

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_c_value      = out_c_value_r;
  assign out_last_element = out_last_r;

  assign dim_m  = eff_dim(rows_r);
  assign dim_n  = eff_dim(cols_r);
  assign dim_k  = eff_dim(inner_r);
  assign m_last = POS_W'(dim_m - DIM_W'(1));
  assign n_last = POS_W'(dim_n - DIM_W'(1));
  assign k_last = POS_W'(dim_k - DIM_W'(1));
  assign cnt_a  = CNT_W'({3'b000, dim_m} * {3'b000, dim_k});
  assign cnt_b  = CNT_W'({3'b000, dim_k} * {3'b000, dim_n});
  assign cnt_c  = CNT_W'({3'b000, dim_m} * {3'b000, dim_n});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= DIM_W'(MAX_DIM);
      cols_r  <= DIM_W'(MAX_DIM);
      inner_r <= DIM_W'(MAX_DIM);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROWS:  rows_r  <= cfg_data;
        REG_COLS:  cols_r  <= cfg_data;
        REG_INNER: inner_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // an index at or past the count restarts at slot 0
  always_comb begin
    a_slot    = ({1'b0, a_idx_r} >= cnt_a) ? '0 : a_idx_r;
    b_slot    = ({1'b0, b_idx_r} >= cnt_b) ? '0 : b_idx_r;
    c_slot    = ({1'b0, c_idx_r} >= cnt_c) ? '0 : c_idx_r;
    a_idx_nxt = ({1'b0, a_slot} + CNT_W'(1) >= cnt_a) ? '0 : a_slot + IDX_W'(1);
    b_idx_nxt = ({1'b0, b_slot} + CNT_W'(1) >= cnt_b) ? '0 : b_slot + IDX_W'(1);
    c_idx_nxt = ({1'b0, c_slot} + CNT_W'(1) >= cnt_c) ? '0 : c_slot + IDX_W'(1);
  end

  assign in_stall  = (upc_r != STEP_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign start     = in_acc && (in_opcode == OP_COMPUTE);
  assign a_we      = in_acc && (in_opcode == OP_LOAD_A);
  assign b_we      = in_acc && (in_opcode == OP_LOAD_B);
  assign ab_load   = sat16(in_value);

  assign uw        = ucode_rom(upc_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign wb_fire   = uw.wb_en && out_free;
  assign last_elem = (i_r == m_last) && (j_r == n_last);
  assign t_more    = (t_r != k_last);

  always_comb begin
    case (uw.cond)
      COND_NEXT:  upc_nxt = upc_r + STEP_W'(1);
      COND_START: upc_nxt = start ? uw.target : upc_r;
      COND_LOOP:  upc_nxt = t_more ? uw.target : upc_r + STEP_W'(1);
      COND_EMIT:  upc_nxt = !out_free ? upc_r : (last_elem ? STEP_IDLE : uw.target);
      default:    upc_nxt = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r   <= STEP_IDLE;
      a_idx_r <= '0;
      b_idx_r <= '0;
      c_idx_r <= '0;
    end else begin
      upc_r <= upc_nxt;
      if (a_we) a_idx_r <= a_idx_nxt;
      if (b_we) b_idx_r <= b_idx_nxt;
      if (in_acc && (in_opcode == OP_LOAD_C)) c_idx_r <= c_idx_nxt;
    end
  end

  // walk: c_addr is linear row-major, a_addr = i*inner + t, b_addr = t*cols + j
  always_ff @(posedge clk) begin
    if (start) begin
      i_r      <= '0;
      j_r      <= '0;
      c_addr_r <= '0;
      a_base_r <= '0;
    end
    if (uw.elem_init) begin
      t_r      <= '0;
      a_addr_r <= a_base_r;
      b_addr_r <= IDX_W'(j_r);
    end
    if (uw.ld_acc) acc_r <= c_vld_rd_r ? c_rd_r : '0;
    if (uw.mul_en) prod_r <= a_rd_r * b_rd_r;
    if (uw.acc_en) begin
      acc_r    <= sat_add48(acc_r, prod_r);
      t_r      <= t_r + POS_W'(1);
      a_addr_r <= a_addr_r + IDX_W'(1);
      b_addr_r <= b_addr_r + IDX_W'(dim_n);
    end
    if (wb_fire) begin
      c_addr_r <= c_addr_r + IDX_W'(1);
      if (j_r == n_last) begin
        j_r      <= '0;
        i_r      <= i_r + POS_W'(1);
        a_base_r <= a_base_r + IDX_W'(dim_k);
      end else begin
        j_r <= j_r + POS_W'(1);
      end
    end
  end

  // A and B stores
  always_ff @(posedge clk) begin
    if (a_we) a_mem[a_slot] <= ab_load;
    a_rd_r <= a_mem[a_addr_r];
  end

  always_ff @(posedge clk) begin
    if (b_we) b_mem[b_slot] <= ab_load;
    b_rd_r <= b_mem[b_addr_r];
  end

  // C store: written by load transactions and by write-back
  assign c_we    = wb_fire || (in_acc && (in_opcode == OP_LOAD_C));
  assign c_waddr = wb_fire ? c_addr_r : c_slot;
  assign c_wdata = wb_fire ? acc_r : in_value;

  always_ff @(posedge clk) begin
    if (c_we) c_mem[c_waddr] <= c_wdata;
    c_rd_r     <= c_mem[c_addr_r];
    c_vld_rd_r <= c_vld_r[c_addr_r];
  end

  // never-written C entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= '0;
    end else if (c_we) begin
      c_vld_r[c_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wb_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_fire) begin
      out_c_value_r <= acc_r;
      out_last_r    <= last_elem;
    end
  end

endmodule

FILE: rtl/core/mma_checker.sv
// ---------------------------------------------------------------------------
// Matrix multiply-accumulate port checker
// Watches the top-level ports over time; bound to the top level below.
// ---------------------------------------------------------------------------
`include "matrix_multiply_accumulate_defines.svh"

module mma_checker
  import mma_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic [1:0]              in_opcode,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [VAL_W-1:0] out_c_value,
  input logic                    out_last_element
);

  logic in_txn, compute_txn, load_txn, out_held;
  assign in_txn      = in_valid && !in_stall;
  assign compute_txn = in_txn && (in_opcode == OP_COMPUTE);
  assign load_txn    = in_txn && (in_opcode != OP_COMPUTE);
  assign out_held    = out_valid && out_stall;

  `MMA_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_valid, "output valid after reset")

  `MMA_ASSERT(a_out_hold,
              out_held |=> out_valid && $stable(out_c_value) && $stable(out_last_element),
              "stalled result changed")

  `MMA_ASSERT(a_compute_busy, compute_txn |=> in_stall, "compute did not stall input")

  `MMA_ASSERT(a_load_no_stall, load_txn |=> !in_stall, "load transaction stalled input")

  // once idle, the only result still waiting is the final element of a run
  `MMA_ASSERT(a_idle_pending_last,
              out_valid && !in_stall |-> out_last_element,
              "idle with non-final result pending")

endmodule

bind matrix_multiply_accumulate mma_checker u_mma_checker (.*);
